// ===== rtl/vg_pkg.sv =====
// Shared types, widths and codes for the voice gate with pre-roll.
// Used by every module of the block; depends on nothing.
package vg_pkg;

  localparam int RING_SAMPLES = 8192;
  localparam int FRAME_MAX    = 1024;

  localparam int POS_W     = $clog2(RING_SAMPLES);
  localparam int LEN_W     = POS_W + 1;
  localparam int FRM_W     = $clog2(FRAME_MAX) + 1;
  localparam int CNT_W     = 8;
  localparam int CFG_W     = LEN_W;
  localparam int CFG_IDX_W = 2;
  localparam int MOD_W     = LEN_W;
  localparam int MOD_CNT_W = $clog2(MOD_W + 1);

  localparam int IN_W  = 8;
  localparam int OUT_W = 48;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HANGOVER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREROLL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME    = 2'd3;

  // event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  localparam int TRIGGER_RESET  = 3;
  localparam int HANGOVER_RESET = 25;
  localparam int PREROLL_RESET  = 4800;
  localparam int FRAME_RESET    = 320;
  localparam int STEP_RESET     = FRAME_RESET % PREROLL_RESET;

  typedef struct packed {
    logic [CNT_W-1:0] trig;
    logic [CNT_W-1:0] hang;
    logic [LEN_W-1:0] len;
    logic [FRM_W-1:0] flen;
    logic [POS_W-1:0] step;
    logic             busy;
    logic             pos_done;
    logic [POS_W-1:0] pos_rem;
  } cfg_t;

  typedef struct packed {
    logic             pass_frame;
    logic [LEN_W-1:0] flush_length;
    logic [POS_W-1:0] flush_start;
    logic [POS_W-1:0] store_at;
    logic             store_frame;
    logic [1:0]       event_res;
    logic             gate_open;
  } res_t;

endpackage

// ===== rtl/vg_mod.sv =====
// Restoring remainder unit, one quotient bit per cycle.
// Depends on vg_pkg for its width.
module vg_mod (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [vg_pkg::MOD_W-1:0] dividend,
  input  logic [vg_pkg::MOD_W-1:0] divisor,
  output logic                     busy,
  output logic                     done,
  output logic [vg_pkg::MOD_W-1:0] remainder
);
  import vg_pkg::*;

  localparam logic [MOD_CNT_W-1:0] LAST = MOD_CNT_W'(MOD_W - 1);

  logic                 running_r, running_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W-1:0]     dvd_r, dvd_nxt;
  logic [MOD_W-1:0]     dsr_r, dsr_nxt;
  logic [MOD_W-1:0]     rem_r, rem_nxt;
  logic [MOD_W-1:0]     shifted;

  // remainder stays below the divisor, so its top bit is always clear
  assign shifted = {rem_r[MOD_W-2:0], dvd_r[MOD_W-1]};

  always_comb begin
    running_nxt = running_r;
    cnt_nxt     = cnt_r;
    dvd_nxt     = dvd_r;
    dsr_nxt     = dsr_r;
    rem_nxt     = rem_r;
    if (start) begin
      running_nxt = 1'b1;
      cnt_nxt     = '0;
      dvd_nxt     = dividend;
      dsr_nxt     = divisor;
      rem_nxt     = '0;
    end else if (running_r) begin
      rem_nxt = (shifted >= dsr_r) ? shifted - dsr_r : shifted;
      dvd_nxt = {dvd_r[MOD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        running_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      running_r <= running_nxt;
      cnt_r     <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = running_r;
  assign done      = running_r && (cnt_r == LAST) && !start;
  assign remainder = rem_nxt;

endmodule

// ===== rtl/vg_cfg.sv =====
// Configuration registers, clamping, and the write-position and frame-step
// remainders that follow a change of ring or frame length. Uses vg_pkg, vg_mod.
module vg_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [vg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vg_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [vg_pkg::POS_W-1:0]     pos_raw,
  output vg_pkg::cfg_t                 cfg
);
  import vg_pkg::*;

  logic [CNT_W-1:0] trig_r, hang_r;
  logic [LEN_W-1:0] plen_r;
  logic [FRM_W-1:0] flen_r;
  logic [POS_W-1:0] step_r;
  logic             start_r;
  logic             len_wr;

  logic [LEN_W-1:0] len_c;
  logic [FRM_W-1:0] flen_c;

  logic             step_busy, step_done, pos_busy, pos_done;
  logic [MOD_W-1:0] step_rem, pos_rem;

  assign len_wr = cfg_we && ((cfg_index == REG_PREROLL) || (cfg_index == REG_FRAME));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r  <= CNT_W'(TRIGGER_RESET);
      hang_r  <= CNT_W'(HANGOVER_RESET);
      plen_r  <= LEN_W'(PREROLL_RESET);
      flen_r  <= FRM_W'(FRAME_RESET);
      step_r  <= POS_W'(STEP_RESET);
      start_r <= 1'b0;
    end else begin
      start_r <= len_wr;
      if (step_done) begin
        step_r <= step_rem[POS_W-1:0];
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TRIGGER:  trig_r <= cfg_wdata[CNT_W-1:0];
          REG_HANGOVER: hang_r <= cfg_wdata[CNT_W-1:0];
          REG_PREROLL:  plen_r <= cfg_wdata[LEN_W-1:0];
          REG_FRAME:    flen_r <= cfg_wdata[FRM_W-1:0];
          default:      ;
        endcase
      end
    end
  end

  always_comb begin
    if (plen_r == '0) begin
      len_c = LEN_W'(1);
    end else if (plen_r > LEN_W'(RING_SAMPLES)) begin
      len_c = LEN_W'(RING_SAMPLES);
    end else begin
      len_c = plen_r;
    end
    flen_c = (flen_r > FRM_W'(FRAME_MAX)) ? FRM_W'(FRAME_MAX) : flen_r;
  end

  vg_mod u_step_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (MOD_W'(flen_c)),
    .divisor   (len_c),
    .busy      (step_busy),
    .done      (step_done),
    .remainder (step_rem)
  );

  vg_mod u_pos_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (MOD_W'(pos_raw)),
    .divisor   (len_c),
    .busy      (pos_busy),
    .done      (pos_done),
    .remainder (pos_rem)
  );

  always_comb begin
    cfg.trig     = (trig_r == '0) ? CNT_W'(1) : trig_r;
    cfg.hang     = (hang_r == '0) ? CNT_W'(1) : hang_r;
    cfg.len      = len_c;
    cfg.flen     = flen_c;
    cfg.step     = step_r;
    cfg.busy     = len_wr || start_r || step_busy || pos_busy;
    cfg.pos_done = pos_done;
    cfg.pos_rem  = pos_rem[POS_W-1:0];
  end

endmodule

// ===== rtl/vg_core.sv =====
// Per-frame gate state, ring pointer and fill update, and the result register.
// Uses vg_pkg; takes clamped settings from vg_cfg.
module vg_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  vg_pkg::cfg_t             cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_voiced,
  output logic                     out_valid,
  input  logic                     out_ready,
  output vg_pkg::res_t             out_res,
  output logic [vg_pkg::POS_W-1:0] pos_raw
);
  import vg_pkg::*;

  logic             speaking_r, speaking_nxt;
  logic [CNT_W-1:0] vcnt_r, vcnt_nxt;
  logic [CNT_W-1:0] scnt_r, scnt_nxt;
  logic [POS_W-1:0] pos_raw_r, pos_red_r, wpos_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic             out_valid_r;
  res_t             res_r, res_nxt;

  logic             accept;
  logic [LEN_W-1:0] fill_c;
  logic [LEN_W:0]   fsum, fadd;
  logic [LEN_W-1:0] adv;

  assign in_ready = !cfg.busy && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    fill_c = (fill_r > cfg.len) ? cfg.len : fill_r;
    fsum   = (LEN_W+1)'(pos_red_r) + (LEN_W+1)'(cfg.len) - (LEN_W+1)'(fill_c);
    fadd   = (LEN_W+1)'(fill_c) + (LEN_W+1)'(cfg.flen);
    adv    = LEN_W'(pos_red_r) + LEN_W'(cfg.step);

    speaking_nxt = speaking_r;
    vcnt_nxt     = vcnt_r;
    scnt_nxt     = scnt_r;
    wpos_nxt     = pos_red_r;
    fill_nxt     = fill_c;
    res_nxt      = '0;
    res_nxt.event_res = EV_NONE;

    if (!speaking_r) begin
      if (in_voiced) begin
        vcnt_nxt = (vcnt_r == CNT_MAX) ? vcnt_r : vcnt_r + 1'b1;
      end else begin
        vcnt_nxt = '0;
      end
      if (vcnt_nxt >= cfg.trig) begin
        speaking_nxt         = 1'b1;
        scnt_nxt             = '0;
        res_nxt.event_res    = EV_START;
        res_nxt.flush_length = fill_c;
        res_nxt.flush_start  = (fsum >= (LEN_W+1)'(cfg.len)) ?
                               POS_W'(fsum - (LEN_W+1)'(cfg.len)) : POS_W'(fsum);
        fill_nxt             = '0;
      end else begin
        res_nxt.store_frame = 1'b1;
        res_nxt.store_at    = pos_red_r;
        wpos_nxt = (adv >= cfg.len) ? POS_W'(adv - cfg.len) : POS_W'(adv);
        fill_nxt = (fadd > (LEN_W+1)'(cfg.len)) ? cfg.len : LEN_W'(fadd);
      end
    end

    if (speaking_nxt) begin
      res_nxt.pass_frame = 1'b1;
      if (in_voiced) begin
        scnt_nxt = '0;
      end else begin
        scnt_nxt = (scnt_nxt == CNT_MAX) ? scnt_nxt : scnt_nxt + 1'b1;
        if (scnt_nxt >= cfg.hang) begin
          speaking_nxt      = 1'b0;
          vcnt_nxt          = '0;
          scnt_nxt          = '0;
          res_nxt.event_res = EV_END;
        end
      end
    end
    res_nxt.gate_open = speaking_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speaking_r  <= 1'b0;
      vcnt_r      <= '0;
      scnt_r      <= '0;
      pos_raw_r   <= '0;
      pos_red_r   <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        speaking_r <= speaking_nxt;
        vcnt_r     <= vcnt_nxt;
        scnt_r     <= scnt_nxt;
        pos_raw_r  <= wpos_nxt;
        pos_red_r  <= wpos_nxt;
        fill_r     <= fill_nxt;
      end else if (cfg.pos_done) begin
        // keep the raw position; the reduced copy follows the new ring length
        pos_red_r <= cfg.pos_rem;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign pos_raw   = pos_raw_r;

endmodule

// ===== rtl/voice_gate_with_preroll.sv =====
// Top level of the per-frame speech gate with pre-roll ring control.
// Depends on vg_pkg, vg_cfg, vg_mod and vg_core.
//
//   channel  | ports             | beat
//   ---------+-------------------+--------------------------------------
//   in       | in_t{valid,ready} | one frame verdict
//   out      | out_t{valid,ready}| one gate decision per verdict
//   cfg      | cfg_we            | one register write, no wait
//
// One verdict is taken per cycle if in_tready is high; its result is registered.
// A write of preroll_length or frame_length starts the shared-length remainder
// units; in_tready stays low while they run (one bit per cycle).
// Reset is synchronous and active low; no clearing pass.
// A stalled output holds its beat; a new verdict is taken as the old one drains.
module voice_gate_with_preroll (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [vg_pkg::IN_W-1:0]      in_tdata,   // [0] voiced, rest zero
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [0] gate_open, [2:1] event_res, [3] store_frame, [16:4] store_at,
  // [29:17] flush_start, [43:30] flush_length, [44] pass_frame, rest zero
  output logic [vg_pkg::OUT_W-1:0]     out_tdata,
  input  logic                         cfg_we,
  input  logic [vg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vg_pkg::CFG_W-1:0]     cfg_wdata
);
  import vg_pkg::*;

  cfg_t             cfg;
  res_t             res;
  logic [POS_W-1:0] pos_raw;

  vg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pos_raw   (pos_raw),
    .cfg       (cfg)
  );

  vg_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_voiced (in_tdata[0]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .pos_raw   (pos_raw)
  );

  assign out_tdata = OUT_W'(res);

`ifndef ASSERT_OFF
  // a length change must block verdicts until the remainders are back
  a_len_write_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == REG_PREROLL || cfg_index == REG_FRAME) |=> !in_tready)
    else $error("verdict accepted while ring length is being reduced");

  // an opening beat flushes and passes, never stores
  a_start_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.event_res == EV_START |->
      res.gate_open && res.pass_frame && !res.store_frame)
    else $error("speech start without pass or with store");

  // a stored frame never passes and leaves the gate closed
  a_store_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.store_frame |->
      !res.gate_open && !res.pass_frame && res.flush_length == '0)
    else $error("stored frame while gate open");

  // stored position lies inside the ring in use unless the ring length just changed
  a_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.store_frame && !$past(cfg.busy) |->
      LEN_W'(res.store_at) < cfg.len)
    else $error("store position outside ring");
`endif

endmodule
